// ===== rtl/lfsd_pkg.sv =====
package lfsd_pkg;

    localparam logic [7:0] PROTOCOL_BYTE = 8'h1a;
    localparam logic [7:0] OPTIONS_BYTE  = 8'h00;
    localparam int MIN_STREAM   = 9;
    localparam int MIN_FRAME    = 7;
    localparam int RECORD_BYTES = 5;

    localparam logic KIND_PIXEL     = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_index;
        logic [7:0]  frame_delay;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_of_run;
    } lfsd_result_t;

    // up to two results per byte, first slot filled first
    typedef struct packed {
        logic         valid0;
        logic         valid1;
        lfsd_result_t res0;
        lfsd_result_t res1;
    } lfsd_push_t;

endpackage

// ===== rtl/lfsd_if.sv =====
interface lfsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source(output valid, output data_byte, input ready);
    modport sink(input valid, input data_byte, output ready);
endinterface

interface lfsd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] frame_index;
    logic [7:0]  frame_delay;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_run;

    modport source(
        output valid, output kind, output frame_index, output frame_delay,
        output pos_x, output pos_y, output red, output green, output blue,
        output last_of_run, input ready
    );
    modport sink(
        input valid, input kind, input frame_index, input frame_delay,
        input pos_x, input pos_y, input red, input green, input blue,
        input last_of_run, output ready
    );
endinterface

// ===== rtl/lfsd_parser.sv =====
module lfsd_parser
    import lfsd_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_fire,
    input  logic [7:0]  data_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output lfsd_push_t  push
);

    localparam logic [2:0] PH_PROTO = 3'd0;
    localparam logic [2:0] PH_OPTS  = 3'd1;
    localparam logic [2:0] PH_DELAY = 3'd2;
    localparam logic [2:0] PH_COUNT = 3'd3;
    localparam logic [2:0] PH_PIXEL = 3'd4;
    localparam logic [2:0] PH_IDLE  = 3'd5;

    localparam logic [2:0] FP_X     = 3'd0;
    localparam logic [2:0] FP_Y     = 3'd1;
    localparam logic [2:0] FP_RED   = 3'd2;
    localparam logic [2:0] FP_GREEN = 3'd3;
    localparam logic [2:0] FP_BLUE  = 3'd4;

    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] seen_reg, seen_next;
    logic [2:0]             phase_reg, phase_next;
    logic [2:0]             field_reg, field_next;
    logic [7:0]             pixels_reg, pixels_next;
    logic [15:0]            frame_reg, frame_next;
    logic [7:0]             delay_reg, delay_next;
    logic [7:0]             x_reg, x_next;
    logic [7:0]             y_reg, y_next;
    logic [7:0]             red_reg, red_next;
    logic [7:0]             green_reg, green_next;

    logic                   active;
    logic [LENGTH_BITS-1:0] remaining;
    logic [LENGTH_BITS-1:0] after;
    logic [7:0]             pixels_dec;
    logic                   pix;
    logic                   close;
    lfsd_result_t           pix_res;
    lfsd_result_t           end_res;

    assign active     = (phase_reg != PH_IDLE) && (seen_reg < len_reg);
    assign remaining  = len_reg - seen_reg;
    assign after      = remaining - LENGTH_BITS'(1);
    assign pixels_dec = pixels_reg - 8'd1;

    always_comb
    begin
        len_next    = len_reg;
        seen_next   = seen_reg;
        phase_next  = phase_reg;
        field_next  = field_reg;
        pixels_next = pixels_reg;
        frame_next  = frame_reg;
        delay_next  = delay_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        pix         = 1'b0;
        close       = 1'b0;

        if (cfg_we)
        begin
            // new length re-arms the parser
            len_next    = LENGTH_BITS'(cfg_wdata);
            seen_next   = '0;
            phase_next  = PH_PROTO;
            field_next  = FP_X;
            pixels_next = '0;
            frame_next  = '0;
        end
        else if (byte_fire && active)
        begin
            seen_next = seen_reg + LENGTH_BITS'(1);
            case (phase_reg)
                PH_PROTO:
                begin
                    if (len_reg < LENGTH_BITS'(MIN_STREAM) || data_byte != PROTOCOL_BYTE)
                        phase_next = PH_IDLE;
                    else
                        phase_next = PH_OPTS;
                end
                PH_OPTS:
                begin
                    phase_next = (data_byte != OPTIONS_BYTE) ? PH_IDLE : PH_DELAY;
                end
                PH_DELAY:
                begin
                    if (remaining < LENGTH_BITS'(MIN_FRAME))
                        phase_next = PH_IDLE;
                    else
                    begin
                        delay_next = data_byte;
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    pixels_next = data_byte;
                    field_next  = FP_X;
                    if (data_byte == 8'd0 || after < LENGTH_BITS'(RECORD_BYTES))
                        close = 1'b1;
                    else
                        phase_next = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    case (field_reg)
                        FP_X:
                        begin
                            x_next     = data_byte;
                            field_next = FP_Y;
                        end
                        FP_Y:
                        begin
                            y_next     = data_byte;
                            field_next = FP_RED;
                        end
                        FP_RED:
                        begin
                            red_next   = data_byte;
                            field_next = FP_GREEN;
                        end
                        FP_GREEN:
                        begin
                            green_next = data_byte;
                            field_next = FP_BLUE;
                        end
                        default:
                        begin
                            pix         = 1'b1;
                            field_next  = FP_X;
                            pixels_next = pixels_dec;
                            if (pixels_dec == 8'd0 || after < LENGTH_BITS'(RECORD_BYTES))
                                close = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (close)
            begin
                frame_next  = frame_reg + 16'd1;
                pixels_next = '0;
                field_next  = FP_X;
                phase_next  = PH_DELAY;
            end
        end
    end

    always_comb
    begin
        pix_res.kind        = KIND_PIXEL;
        pix_res.frame_index = frame_reg;
        pix_res.frame_delay = delay_reg;
        pix_res.pos_x       = x_reg;
        pix_res.pos_y       = y_reg;
        pix_res.red         = red_reg;
        pix_res.green       = green_reg;
        pix_res.blue        = data_byte;
        pix_res.last_of_run = !close;

        end_res.kind        = KIND_FRAME_END;
        end_res.frame_index = frame_reg;
        end_res.frame_delay = delay_reg;
        end_res.pos_x       = '0;
        end_res.pos_y       = '0;
        end_res.red         = '0;
        end_res.green       = '0;
        end_res.blue        = '0;
        end_res.last_of_run = 1'b1;

        push.valid0 = pix || close;
        push.valid1 = pix && close;
        push.res0   = pix ? pix_res : end_res;
        push.res1   = end_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            seen_reg   <= '0;
            phase_reg  <= PH_PROTO;
            field_reg  <= FP_X;
            pixels_reg <= '0;
            frame_reg  <= '0;
            delay_reg  <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            phase_reg  <= phase_next;
            field_reg  <= field_next;
            pixels_reg <= pixels_next;
            frame_reg  <= frame_next;
            delay_reg  <= delay_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0 && push.res0.kind == KIND_PIXEL)
        else $error("second result without a pixel result first");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid0 |-> push.res0.last_of_run == !push.valid1)
        else $error("last_of_run misplaced");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> seen_reg == '0 && phase_reg == PH_PROTO && frame_reg == 16'd0)
        else $error("length write did not re-arm parser");

endmodule

// ===== rtl/lfsd_result_fifo.sv =====
module lfsd_result_fifo
    import lfsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfsd_push_t           push,
    output logic                 room,
    lfsd_result_if.source        result
);

    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic [QUEUE_AW:0]   push_n;
    logic [QUEUE_AW-1:0] wr_ptr_second;
    logic                pop;
    lfsd_result_t        entry_reg [QUEUE_DEPTH];
    lfsd_result_t        head;

    assign push_n        = (QUEUE_AW+1)'(push.valid0) + (QUEUE_AW+1)'(push.valid1);
    assign pop           = result.valid && result.ready;
    assign count_next    = count_reg + push_n - (QUEUE_AW+1)'(pop);
    assign wr_ptr_next   = wr_ptr_reg + push_n[QUEUE_AW-1:0];
    assign rd_ptr_next   = rd_ptr_reg + QUEUE_AW'(pop);
    assign wr_ptr_second = wr_ptr_reg + QUEUE_AW'(1);

    // one byte may leave two results, so hold space for a pair
    assign room = count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);

    assign head               = entry_reg[rd_ptr_reg];
    assign result.valid       = count_reg != '0;
    assign result.kind        = head.kind;
    assign result.frame_index = head.frame_index;
    assign result.frame_delay = head.frame_delay;
    assign result.pos_x       = head.pos_x;
    assign result.pos_y       = head.pos_y;
    assign result.red         = head.red;
    assign result.green       = head.green;
    assign result.blue        = head.blue;
    assign result.last_of_run = head.last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push.valid1)
            entry_reg[wr_ptr_second] <= push.res1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid0 |-> count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2))
        else $error("push without room for a pair");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push.valid0 |=> count_reg == $past(count_reg) - (QUEUE_AW+1)'(1))
        else $error("queue count off after transfer out");

endmodule

// ===== rtl/led_frame_stream_deframer.sv =====
// channel   dir  payload                                      transfer when
// stream    in   data_byte                                    valid && ready
// result    out  kind, frame_index, frame_delay, pos_x/y,     valid && ready
//                red, green, blue, last_of_run
// cfg       in   cfg_wdata (stream_length)                    cfg_we
//
// one byte per cycle while stream.ready is high; each byte is parsed in the cycle it transfers in
// a byte yields up to two results, queued in a four-entry result queue
// stream.ready drops only while the queue has fewer than two free entries
// results leave one per cycle; a pixel plus frame end is followed by at least
// one byte with no result, so the stream side never stalls while the result
// side never stalls; rst_n clears all control state
module led_frame_stream_deframer
    import lfsd_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    lfsd_byte_if.sink     stream,
    lfsd_result_if.source result,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);

    logic       room;
    logic       byte_fire;
    lfsd_push_t push;

    assign stream.ready = room;
    assign byte_fire    = stream.valid && stream.ready;

    lfsd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .data_byte (stream.data_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    lfsd_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

// ===== tb/led_frame_stream_deframer_tb.sv =====
`timescale 1ns / 100ps

module led_frame_stream_deframer_tb;
    import lfsd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT  = 50;

    typedef enum logic [2:0] {
        PH_PROTO,
        PH_OPTS,
        PH_DELAY,
        PH_COUNT,
        PH_PIXEL,
        PH_IDLE
    } parse_phase_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    lfsd_byte_if   stream_ch();
    lfsd_result_if result_ch();

    led_frame_stream_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // parser state mirrored from the byte transfers
    parse_phase_t parse_phase;
    logic [15:0]  length_reg;
    logic [15:0]  bytes_taken;
    logic [2:0]   field_pos;
    logic [7:0]   pixels_left;
    logic [15:0]  frame_count;
    logic [7:0]   held_delay;
    logic [7:0]   held_x;
    logic [7:0]   held_y;
    logic [7:0]   held_red;
    logic [7:0]   held_green;

    lfsd_result_t due_results[$];
    logic [7:0]   stream_bytes[$];

    int error_count;
    int cycle_count;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%s", msg);
    endtask

    function automatic string result_text(input lfsd_result_t r);
        return $sformatf("kind %0d frame %0d delay %0d x %0d y %0d rgb %0d/%0d/%0d last %0d",
                         r.kind, r.frame_index, r.frame_delay, r.pos_x, r.pos_y,
                         r.red, r.green, r.blue, r.last_of_run);
    endfunction

    task automatic rearm_parser();
        parse_phase = PH_PROTO;
        bytes_taken = '0;
        field_pos   = '0;
        pixels_left = '0;
        frame_count = '0;
    endtask

    task automatic reset_parser();
        length_reg = '0;
        rearm_parser();
        held_delay = '0;
        held_x     = '0;
        held_y     = '0;
        held_red   = '0;
        held_green = '0;
    endtask

    function automatic lfsd_result_t make_result(input logic kind, input logic [7:0] x,
                                                 input logic [7:0] y, input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b);
        lfsd_result_t res;
        res.kind        = kind;
        res.frame_index = frame_count;
        res.frame_delay = held_delay;
        res.pos_x       = x;
        res.pos_y       = y;
        res.red         = r;
        res.green       = g;
        res.blue        = b;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        int remaining;
        int n;
        bit close;
        n = 0;
        close = 1'b0;
        if (parse_phase == PH_IDLE || bytes_taken >= length_reg)
            return;
        remaining = int'(length_reg) - int'(bytes_taken);
        bytes_taken = bytes_taken + 16'd1;
        case (parse_phase)
            PH_PROTO:
                parse_phase = (length_reg < MIN_STREAM || b != PROTOCOL_BYTE) ? PH_IDLE : PH_OPTS;
            PH_OPTS:
                parse_phase = (b != OPTIONS_BYTE) ? PH_IDLE : PH_DELAY;
            PH_DELAY:
                if (remaining < MIN_FRAME)
                    parse_phase = PH_IDLE;
                else
                begin
                    held_delay = b;
                    parse_phase = PH_COUNT;
                end
            PH_COUNT:
            begin
                pixels_left = b;
                field_pos = '0;
                if (b == 8'd0 || remaining - 1 < RECORD_BYTES)
                    close = 1'b1;
                else
                    parse_phase = PH_PIXEL;
            end
            PH_PIXEL:
                case (field_pos)
                    3'd0:
                    begin
                        held_x = b;
                        field_pos = 3'd1;
                    end
                    3'd1:
                    begin
                        held_y = b;
                        field_pos = 3'd2;
                    end
                    3'd2:
                    begin
                        held_red = b;
                        field_pos = 3'd3;
                    end
                    3'd3:
                    begin
                        held_green = b;
                        field_pos = 3'd4;
                    end
                    default:
                    begin
                        due_results.push_back(make_result(KIND_PIXEL, held_x, held_y,
                                                          held_red, held_green, b));
                        n++;
                        field_pos = '0;
                        pixels_left = pixels_left - 8'd1;
                        if (pixels_left == 8'd0 || remaining - 1 < RECORD_BYTES)
                            close = 1'b1;
                    end
                endcase
            default:
                parse_phase = PH_IDLE;
        endcase
        if (close)
        begin
            due_results.push_back(make_result(KIND_FRAME_END, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
            n++;
            frame_count = frame_count + 16'd1;
            pixels_left = '0;
            field_pos = '0;
            parse_phase = PH_DELAY;
        end
        if (n > 0)
            due_results[due_results.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic check_result();
        lfsd_result_t got;
        lfsd_result_t want;
        got.kind        = result_ch.kind;
        got.frame_index = result_ch.frame_index;
        got.frame_delay = result_ch.frame_delay;
        got.pos_x       = result_ch.pos_x;
        got.pos_y       = result_ch.pos_y;
        got.red         = result_ch.red;
        got.green       = result_ch.green;
        got.blue        = result_ch.blue;
        got.last_of_run = result_ch.last_of_run;
        if (due_results.size() == 0)
            report_mismatch({"unexpected result: ", result_text(got)});
        else
        begin
            want = due_results.pop_front();
            if (got !== want)
                report_mismatch({"result mismatch: got ", result_text(got),
                                 " expected ", result_text(want)});
        end
    endtask

    // observes config, byte and result transfers in model order, drives result ready
    initial
    begin
        error_count = 0;
        reset_parser();
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                reset_parser();
            else
            begin
                if (cfg_we)
                begin
                    length_reg = cfg_wdata;
                    rearm_parser();
                end
                if (stream_ch.valid && stream_ch.ready)
                    parse_byte(stream_ch.data_byte);
                if (result_ch.valid && result_ch.ready)
                    check_result();
            end
            result_ch.ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 8)
        begin
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        stream_ch.valid     <= 1'b1;
        stream_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!stream_ch.ready);
    endtask

    task automatic drain_results();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_stream_length(input logic [15:0] len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_stream(input logic [15:0] len);
        drain_results();
        write_stream_length(len);
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i]);
    endtask

    // mostly well-formed: valid header, frames with random content, some cut short
    task automatic make_stream(input int frames);
        int count;
        int pixels;
        stream_bytes.delete();
        stream_bytes.push_back(($urandom_range(99) < 6) ? 8'($urandom) : PROTOCOL_BYTE);
        stream_bytes.push_back(($urandom_range(99) < 6) ? 8'($urandom_range(1, 255))
                                                        : OPTIONS_BYTE);
        for (int f = 0; f < frames; f++)
        begin
            stream_bytes.push_back(8'($urandom));
            count = ($urandom_range(99) < 10) ? $urandom_range(255) : $urandom_range(4);
            stream_bytes.push_back(8'(count));
            pixels = (count > 6) ? $urandom_range(6) : count;
            repeat (5 * pixels) stream_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4))
                if (stream_bytes.size() > 1)
                    void'(stream_bytes.pop_back());
    endtask

    task automatic test_header_checks();
        stream_bytes = '{PROTOCOL_BYTE};
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i]);
        stream_bytes = '{PROTOCOL_BYTE};
        run_stream(16'd8);
        stream_bytes = '{8'h1b};
        run_stream(16'd9);
        stream_bytes = '{PROTOCOL_BYTE, 8'h01};
        run_stream(16'd9);
    endtask

    task automatic test_frame_closing();
        // empty frame, pixel with frame end, rejected delay, byte past the end
        stream_bytes = '{PROTOCOL_BYTE, OPTIONS_BYTE, 8'hff, 8'h00,
                         8'h05, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                         8'h00, PROTOCOL_BYTE};
        run_stream(16'd12);
        // frame cut short after its first pixel
        stream_bytes = '{PROTOCOL_BYTE, OPTIONS_BYTE, 8'h80, 8'h02,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        run_stream(16'd9);
    endtask

    task automatic test_random_streams(input int byte_budget);
        int sent;
        int size;
        int pick;
        logic [15:0] len;
        sent = 0;
        while (sent < byte_budget)
        begin
            make_stream($urandom_range(1, 6));
            size = stream_bytes.size();
            pick = $urandom_range(99);
            if (pick < 75)
                len = 16'(size);
            else if (pick < 85)
                len = 16'($urandom_range(size));
            else if (pick < 92)
                len = 16'(size + $urandom_range(1, 4));
            else
            begin
                len = 16'(size);
                repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
            end
            sent += stream_bytes.size();
            run_stream(len);
        end
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        for (int s = 0; s < 4; s++)
        begin
            make_stream($urandom_range(2, 5));
            run_stream(16'(stream_bytes.size()));
        end
        drain_results();
        calm = 1'b0;
    endtask

    task automatic test_length_extremes();
        make_stream(10);
        run_stream(16'hffff);
        stream_bytes.delete();
        stream_bytes.push_back(PROTOCOL_BYTE);
        stream_bytes.push_back(OPTIONS_BYTE);
        repeat (6) stream_bytes.push_back(8'($urandom));
        run_stream(16'd0);
    endtask

    initial
    begin
        calm = 1'b0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        stream_ch.valid     <= 1'b0;
        stream_ch.data_byte <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_checks();
        test_frame_closing();
        test_random_streams(1100);
        test_back_to_back();
        test_length_extremes();
        drain_results();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lfsd_pkg.sv
rtl/lfsd_if.sv
rtl/lfsd_parser.sv
rtl/lfsd_result_fifo.sv
rtl/led_frame_stream_deframer.sv
tb/led_frame_stream_deframer_tb.sv
